@@ hdl/integer_to_radix_text_macros.svh @@
// Assertion helpers used by the checker module itrt_chk.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ITRT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("integer_to_radix_text: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ITRT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("integer_to_radix_text: check failed");

`endif

@@ hdl/itrt_pkg.sv @@
package itrt_pkg;

  localparam int VALUE_BITS = 64;
  localparam int VALUE_IN_W = 64;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 7;

  // Quotient bits resolved per divider cycle
  localparam int DIV_BPC    = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + DIV_BPC - 1) / DIV_BPC;
  localparam int DIV_W      = DIV_STEPS * DIV_BPC;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int ADDR_W     = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 7'h66;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOWER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

@@ hdl/itrt_ram.sv @@
module itrt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/itrt_div.sv @@
// Radix divider: restoring division by a 5-bit divisor, DIV_BPC quotient bits a cycle.
module itrt_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [itrt_pkg::VALUE_BITS-1:0]     dividend_i,
  input  logic [itrt_pkg::RADIX_W-1:0]        divisor_i,
  output logic                                done_o,
  output logic [itrt_pkg::VALUE_BITS-1:0]     quotient_o,
  output logic [itrt_pkg::DIGIT_W-1:0]        remainder_o
);

  logic [itrt_pkg::DIV_W-1:0]     work_q, work_d;
  logic [itrt_pkg::DIGIT_W-1:0]   rem_q, rem_d;
  logic [itrt_pkg::RADIX_W-1:0]   divisor_q;
  logic [itrt_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           run_q;
  logic                           done_q;

  always_comb begin
    logic [itrt_pkg::RADIX_W-1:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < itrt_pkg::DIV_BPC; i++) begin
      trial  = {rem_d, work_d[itrt_pkg::DIV_W-1]};
      work_d = {work_d[itrt_pkg::DIV_W-2:0], 1'b0};
      // Remainder stays below the divisor, so four bits hold it
      if (trial >= divisor_q) begin
        rem_d     = itrt_pkg::DIGIT_W'(trial - divisor_q);
        work_d[0] = 1'b1;
      end else begin
        rem_d = trial[itrt_pkg::DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= itrt_pkg::DIV_CNT_W'(itrt_pkg::DIV_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == itrt_pkg::DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q    <= itrt_pkg::DIV_W'(dividend_i);
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[itrt_pkg::VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

@@ hdl/integer_to_radix_text.sv @@
// Integer to radix text converter.
// Pulse start with value_i (signed) and base_i (2..16, codes outside saturate)
// while busy is low; the request is taken at that edge and busy rises.
// The magnitude is divided by the base repeatedly in one shared divider that
// resolves 8 quotient bits per cycle, one division per digit. Remainders go
// into a 64-entry digit RAM, least significant first, and are then read back
// most significant first. Characters come out one per cycle on character_o,
// each marked by a one-cycle strobe_o, with negative_o set on every character
// of a negative value and last_o on the final, least significant one. Zero
// gives one '0'. busy drops as the last character goes out, so the next
// request may be taken in that cycle.
// The receiver cannot stall: each strobe is a one-cycle request.
// Reset clears the sequencer and the strobe; the digit RAM is not cleared.
module integer_to_radix_text (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [itrt_pkg::VALUE_IN_W-1:0]  value_i,
  input  logic [itrt_pkg::RADIX_W-1:0]     base_i,
  output logic                             strobe_o,
  output logic [itrt_pkg::CHAR_W-1:0]      character_o,
  output logic                             negative_o,
  output logic                             last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [itrt_pkg::ADDR_W-1:0]     ptr_q, ptr_d;
  logic                            neg_q;
  logic [itrt_pkg::RADIX_W-1:0]    radix_q;

  logic [itrt_pkg::VALUE_BITS-1:0] raw;
  logic [itrt_pkg::VALUE_BITS-1:0] mag;
  logic [itrt_pkg::RADIX_W-1:0]    radix_sat;

  logic                            div_start;
  logic [itrt_pkg::VALUE_BITS-1:0] div_dividend;
  logic [itrt_pkg::RADIX_W-1:0]    div_divisor;
  logic                            div_done;
  logic [itrt_pkg::VALUE_BITS-1:0] div_quotient;
  logic [itrt_pkg::DIGIT_W-1:0]    div_remainder;

  logic                            ram_we;
  logic [itrt_pkg::ADDR_W-1:0]     ram_raddr;
  logic [itrt_pkg::DIGIT_W-1:0]    ram_rdata;

  logic                            emit;
  logic                            accept;

  logic                            strobe_q;
  logic [itrt_pkg::CHAR_W-1:0]     char_q;
  logic                            neg_out_q;
  logic                            last_q;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign raw = value_i[itrt_pkg::VALUE_BITS-1:0];
  // Most negative value negates to itself, read as unsigned it is exact
  assign mag = raw[itrt_pkg::VALUE_BITS-1] ? (~raw + itrt_pkg::VALUE_BITS'(1)) : raw;

  always_comb begin
    if (base_i < itrt_pkg::RADIX_MIN) begin
      radix_sat = itrt_pkg::RADIX_MIN;
    end else if (base_i > itrt_pkg::RADIX_MAX) begin
      radix_sat = itrt_pkg::RADIX_MAX;
    end else begin
      radix_sat = base_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    div_start    = 1'b0;
    div_dividend = div_quotient;
    div_divisor  = radix_q;
    ram_we       = 1'b0;
    ram_raddr    = ptr_q;
    emit         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          div_start    = 1'b1;
          div_dividend = mag;
          div_divisor  = radix_sat;
          ptr_d        = '0;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ram_we = 1'b1;
          if (div_quotient != '0 &&
              ptr_q != itrt_pkg::ADDR_W'(itrt_pkg::VALUE_BITS - 1)) begin
            div_start = 1'b1;
            ptr_d     = ptr_q + 1'b1;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        emit = 1'b1;
        // Fetch the next lower digit while this one goes out
        ram_raddr = ptr_q - 1'b1;
        if (ptr_q == '0) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q   <= raw[itrt_pkg::VALUE_BITS-1];
      radix_q <= radix_sat;
    end
    if (emit) begin
      char_q    <= itrt_pkg::digit_char(ram_rdata);
      neg_out_q <= neg_q;
      last_q    <= (ptr_q == '0);
    end
  end

  itrt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  itrt_ram #(
    .WIDTH (itrt_pkg::DIGIT_W),
    .DEPTH (itrt_pkg::VALUE_BITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (div_remainder),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign negative_o  = neg_out_q;
  assign last_o      = last_q;

endmodule

@@ hdl/itrt_chk.sv @@
`include "integer_to_radix_text_macros.svh"

module itrt_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe_o,
  input logic [itrt_pkg::CHAR_W-1:0] character_o,
  input logic                        negative_o,
  input logic                        last_o
);

  // A taken request holds the block
  `ITRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // Only digit characters leave the block
  `ITRT_ASSERT_IMP(a_char_range, strobe_o, (character_o >= itrt_pkg::CHAR_ZERO && character_o <= itrt_pkg::CHAR_NINE) || (character_o >= itrt_pkg::CHAR_LOWER_A && character_o <= itrt_pkg::CHAR_LOWER_F))

  // More characters pending keeps the block busy
  `ITRT_ASSERT_IMP(a_run_busy, strobe_o && !last_o, busy)

  // A run streams without gaps and keeps its sign
  `ITRT_ASSERT_NEXT(a_run_sign, strobe_o && !last_o, strobe_o && negative_o == $past(negative_o))

endmodule

bind integer_to_radix_text itrt_chk u_itrt_chk (.*);

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 185;

  typedef struct packed {
    logic [itrt_pkg::CHAR_W-1:0] character;
    logic                        negative;
    logic                        last;
  } digit_char_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [itrt_pkg::VALUE_IN_W-1:0] value_i = '0;
  logic [itrt_pkg::RADIX_W-1:0]    base_i = '0;
  logic                            strobe_o;
  logic [itrt_pkg::CHAR_W-1:0]     character_o;
  logic                            negative_o;
  logic                            last_o;

  digit_char_t expected_chars[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          idle_enabled = 1'b1;

  integer_to_radix_text dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .base_i      (base_i),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .negative_o  (negative_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d characters still pending", $time, expected_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Convert magnitude to digits, push characters most significant first.
  task automatic predict_digit_chars(input logic [itrt_pkg::VALUE_IN_W-1:0] value,
                                     input logic [itrt_pkg::RADIX_W-1:0] base);
    logic [itrt_pkg::VALUE_BITS-1:0] raw;
    logic [itrt_pkg::VALUE_BITS-1:0] quot;
    logic [6:0]                      radix;
    logic                            neg;
    logic [3:0]                      digits[64];
    int                              n;
    digit_char_t                     item;
    raw = value[itrt_pkg::VALUE_BITS-1:0];
    neg = raw[itrt_pkg::VALUE_BITS-1];
    radix = 7'(base);
    if (radix < 7'(itrt_pkg::RADIX_MIN)) radix = 7'(itrt_pkg::RADIX_MIN);
    if (radix > 7'(itrt_pkg::RADIX_MAX)) radix = 7'(itrt_pkg::RADIX_MAX);
    quot = neg ? (itrt_pkg::VALUE_BITS'(0) - raw) : raw;
    n = 0;
    do begin
      digits[n] = 4'(quot % radix);
      quot = quot / radix;
      n++;
    end while (quot != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < 4'd10) begin
        item.character = 7'h30 + 7'(digits[k]);
      end else begin
        item.character = 7'h61 + 7'(digits[k]) - 7'd10;
      end
      item.negative = neg;
      item.last = (k == 0);
      expected_chars.push_back(item);
    end
  endtask

  // Hold the request until an edge sees start high and busy low.
  task automatic send_request(input logic [itrt_pkg::VALUE_IN_W-1:0] value,
                              input logic [itrt_pkg::RADIX_W-1:0] base);
    int gap;
    bit taken;
    gap = idle_enabled ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    value_i <= value;
    base_i <= base;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    predict_digit_chars(value, base);
  endtask

  always @(negedge clk_i) begin
    digit_char_t want;
    if (rst_ni && strobe_o) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h neg %b last %b",
                 $time, character_o, negative_o, last_o);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.character) begin
          $display("%0t: character mismatch, expected %h, got %h",
                   $time, want.character, character_o);
          error_count++;
        end
        if (negative_o !== want.negative) begin
          $display("%0t: negative mismatch, expected %b, got %b",
                   $time, want.negative, negative_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_zero();
    send_request('0, 5'd10);
    send_request('0, 5'd0);
  endtask

  task automatic test_extremes();
    send_request(64'h7fff_ffff_ffff_ffff, 5'd2);
    send_request(64'h8000_0000_0000_0000, 5'd2);
    send_request(64'h8000_0000_0000_0000, 5'd16);
    send_request(64'hffff_ffff_ffff_ffff, 5'd10);
    send_request(64'd1, 5'd2);
  endtask

  task automatic test_base_saturation();
    send_request(-64'sd5, 5'd1);
    send_request(64'd12345, 5'd0);
    send_request(64'hdead_beef, 5'd17);
    send_request(-64'sh1234, 5'd31);
  endtask

  task automatic test_hex_digits();
    send_request(64'h1234_5678_9abc_def0, 5'd16);
  endtask

  task automatic test_radix_sweep();
    logic [itrt_pkg::VALUE_IN_W-1:0] v;
    for (int b = 3; b <= 15; b++) begin
      v = {$urandom, $urandom};
      send_request(v, 5'(b));
    end
  endtask

  task automatic test_random();
    logic [itrt_pkg::VALUE_IN_W-1:0] v;
    logic [itrt_pkg::RADIX_W-1:0]    b;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: v = {$urandom, $urandom};
        1: begin
          v = 64'($urandom_range(0, 300));
          if ($urandom_range(0, 1)) v = 64'd0 - v;
        end
        2: begin
          v = {$urandom, $urandom} >> $urandom_range(0, 63);
          if ($urandom_range(0, 1)) v = 64'd0 - v;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: v = '0;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = 64'h8000_0000_0000_0000;
            3: v = '1;
            default: v = 64'd1 << $urandom_range(0, 62);
          endcase
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        b = 5'($urandom_range(0, 31));
      end else begin
        b = 5'($urandom_range(2, 16));
      end
      send_request(v, b);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_zero();
    test_extremes();
    test_base_saturation();
    test_hex_digits();
    test_radix_sweep();
    test_random();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
